// ----- rtl/core/dcfr_pkg.sv -----
// shared constants, codes, result word type and helper functions for the drive command block
package dcfr_pkg;

  // width of the two millisecond counters (17 to 32)
  localparam int TIME_COUNT_WIDTH = 17;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [15:0] TIMEOUT_RESET  = 16'd500;
  localparam logic [15:0] INTERVAL_RESET = 16'd50;
  localparam logic [6:0]  SPEED_STEP_RESET = 7'd10;
  localparam logic [6:0]  ANGLE_STEP_RESET = 7'd5;

  localparam int STEER_MAX  = 90;
  localparam int STEER_FULL = 127;

  // divide by STEER_FULL as multiply by a rounded-up reciprocal and shift
  localparam int STEER_SHIFT = 21;
  localparam int STEER_RECIP = ((1 << STEER_SHIFT) + STEER_FULL - 1) / STEER_FULL;

  typedef enum logic {
    REQ_PACKET = 1'b0,
    REQ_TICK   = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    CMD_DRIVE      = 3'd0,
    CMD_SET_BRAKES = 3'd1,
    CMD_ESTOP      = 3'd2,
    CMD_KEEPALIVE  = 3'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_MOTORS = 2'd1,
    ACT_BRAKES = 2'd2,
    ACT_STOP   = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    REG_TIMEOUT    = 2'd0,
    REG_INTERVAL   = 2'd1,
    REG_SPEED_STEP = 2'd2,
    REG_ANGLE_STEP = 2'd3
  } reg_idx_t;

  typedef struct packed {
    act_t               action;
    logic signed [7:0]  motor_speed;
    logic signed [7:0]  steer_angle;
    logic signed [7:0]  brake_front;
    logic signed [7:0]  brake_rear;
    logic               failsafe_active;
  } res_t;

  // steering byte to degrees, truncated toward zero
  function automatic logic signed [7:0] steer_deg(logic signed [7:0] p);
    logic [7:0]        mag;
    logic [13:0]       prod;
    logic [29:0]       scaled;
    logic [6:0]        q;
    logic signed [7:0] deg;
    // work on the magnitude so the quotient truncates toward zero
    mag    = p[7] ? unsigned'(-p) : unsigned'(p);
    prod   = {6'd0, mag} * 14'(STEER_MAX);
    scaled = {16'd0, prod} * 30'(STEER_RECIP);
    q      = scaled[STEER_SHIFT+6:STEER_SHIFT];
    deg    = signed'({1'b0, q});
    return p[7] ? -deg : deg;
  endfunction

  // one failsafe step toward zero, clamped inside one step
  function automatic logic signed [7:0] ramp_toward_zero(logic signed [7:0] v,
                                                        logic [6:0] step);
    logic signed [8:0] vw;
    logic signed [8:0] sw;
    logic signed [8:0] res;
    vw = {v[7], v};
    sw = signed'({2'b00, step});
    if (vw > sw) begin
      res = vw - sw;
    end else if (vw < -sw) begin
      res = vw + sw;
    end else begin
      res = '0;
    end
    return signed'(res[7:0]);
  endfunction

  function automatic logic [TIME_COUNT_WIDTH-1:0] sat_inc(
      logic [TIME_COUNT_WIDTH-1:0] c);
    return (&c) ? c : c + TIME_COUNT_WIDTH'(1);
  endfunction

endpackage

// ----- rtl/core/drive_command_failsafe_ramp.sv -----
// Drive command block with failsafe ramp. Each accepted word is a decoded command
// packet or a one millisecond tick; every word gives exactly one result word. The
// command decode, watchdog counters and ramp step are one combinational pass from
// the state registers and the input ports into a two-entry output buffer, so a new
// word is taken every cycle: the block stalls its input only while both output
// entries are full. Each result is registered into the head entry, or into the
// skid entry while the head entry waits. Configuration registers sit on a
// byte-addressed APB-style port (timeout at 0x0, step interval at 0x4, speed step
// at 0x8, angle step at 0xC) and should be written only while the block is idle.
module drive_command_failsafe_ramp (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_req_type,
  input  logic [2:0]                          in_command,
  input  logic signed [7:0]                   in_first_param,
  input  logic signed [7:0]                   in_second_param,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_action,
  output logic signed [7:0]                   out_motor_speed,
  output logic signed [7:0]                   out_steer_angle,
  output logic signed [7:0]                   out_brake_front,
  output logic signed [7:0]                   out_brake_rear,
  output logic                                out_failsafe_active,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dcfr_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [dcfr_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [dcfr_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int TW = dcfr_pkg::TIME_COUNT_WIDTH;

  // configuration registers
  logic [15:0] timeout_r;
  logic [15:0] interval_r;
  logic [6:0]  speed_step_r;
  logic [6:0]  angle_step_r;

  // block state
  logic signed [7:0] speed_r, speed_nxt;
  logic signed [7:0] angle_r, angle_nxt;
  logic [TW-1:0]     since_packet_r, since_packet_nxt;
  logic [TW-1:0]     since_step_r, since_step_nxt;

  // output buffer: head entry drives the ports, skid entry catches a word under stall
  dcfr_pkg::res_t out_word_r;
  dcfr_pkg::res_t skid_word_r;
  logic           out_valid_r;
  logic           skid_valid_r;

  dcfr_pkg::res_t    res;
  dcfr_pkg::reg_idx_t cfg_idx;
  dcfr_pkg::cmd_t    cmd;
  logic              cfg_wr;
  logic              in_acc;
  logic              out_take;
  logic [TW-1:0]     packet_inc;
  logic [TW-1:0]     step_inc;
  logic [TW-1:0]     timeout_ext;
  logic [TW-1:0]     interval_ext;

  assign pready  = 1'b1;
  assign cfg_idx = dcfr_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    unique case (cfg_idx)
      dcfr_pkg::REG_TIMEOUT:    prdata = dcfr_pkg::CFG_DATA_W'(timeout_r);
      dcfr_pkg::REG_INTERVAL:   prdata = dcfr_pkg::CFG_DATA_W'(interval_r);
      dcfr_pkg::REG_SPEED_STEP: prdata = dcfr_pkg::CFG_DATA_W'(speed_step_r);
      dcfr_pkg::REG_ANGLE_STEP: prdata = dcfr_pkg::CFG_DATA_W'(angle_step_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r    <= dcfr_pkg::TIMEOUT_RESET;
      interval_r   <= dcfr_pkg::INTERVAL_RESET;
      speed_step_r <= dcfr_pkg::SPEED_STEP_RESET;
      angle_step_r <= dcfr_pkg::ANGLE_STEP_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        dcfr_pkg::REG_TIMEOUT:    timeout_r    <= pwdata[15:0];
        dcfr_pkg::REG_INTERVAL:   interval_r   <= pwdata[15:0];
        dcfr_pkg::REG_SPEED_STEP: speed_step_r <= pwdata[6:0];
        dcfr_pkg::REG_ANGLE_STEP: angle_step_r <= pwdata[6:0];
      endcase
    end
  end

  // handshake
  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid & ~in_stall;
  assign out_take = out_valid_r & ~out_stall;

  assign timeout_ext  = TW'(timeout_r);
  assign interval_ext = TW'(interval_r);
  assign packet_inc   = dcfr_pkg::sat_inc(since_packet_r);
  assign step_inc     = dcfr_pkg::sat_inc(since_step_r);
  assign cmd          = dcfr_pkg::cmd_t'(in_command);

  always_comb begin
    speed_nxt        = speed_r;
    angle_nxt        = angle_r;
    since_packet_nxt = since_packet_r;
    since_step_nxt   = since_step_r;
    res              = '0;
    res.action       = dcfr_pkg::ACT_NONE;
    if (in_req_type == dcfr_pkg::REQ_PACKET) begin
      unique case (cmd)
        dcfr_pkg::CMD_DRIVE: begin
          speed_nxt        = in_first_param;
          angle_nxt        = dcfr_pkg::steer_deg(in_second_param);
          since_packet_nxt = '0;
          res.action       = dcfr_pkg::ACT_MOTORS;
          res.motor_speed  = in_first_param;
          res.steer_angle  = dcfr_pkg::steer_deg(in_second_param);
        end
        dcfr_pkg::CMD_SET_BRAKES: begin
          since_packet_nxt = '0;
          res.action       = dcfr_pkg::ACT_BRAKES;
          res.brake_front  = in_first_param;
          res.brake_rear   = in_second_param;
        end
        dcfr_pkg::CMD_ESTOP: begin
          speed_nxt        = '0;
          angle_nxt        = '0;
          since_packet_nxt = '0;
          res.action       = dcfr_pkg::ACT_STOP;
        end
        dcfr_pkg::CMD_KEEPALIVE: begin
          since_packet_nxt = '0;
        end
        default: begin
          // unknown command leaves everything alone
        end
      endcase
    end else begin
      since_packet_nxt = packet_inc;
      since_step_nxt   = step_inc;
      if (packet_inc > timeout_ext && step_inc >= interval_ext) begin
        since_step_nxt  = '0;
        speed_nxt       = dcfr_pkg::ramp_toward_zero(speed_r, speed_step_r);
        angle_nxt       = dcfr_pkg::ramp_toward_zero(angle_r, angle_step_r);
        res.action      = dcfr_pkg::ACT_MOTORS;
        res.motor_speed = dcfr_pkg::ramp_toward_zero(speed_r, speed_step_r);
        res.steer_angle = dcfr_pkg::ramp_toward_zero(angle_r, angle_step_r);
      end
    end
    res.failsafe_active = (since_packet_nxt > timeout_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r        <= '0;
      angle_r        <= '0;
      since_packet_r <= '0;
      since_step_r   <= '0;
    end else if (in_acc) begin
      speed_r        <= speed_nxt;
      angle_r        <= angle_nxt;
      since_packet_r <= since_packet_nxt;
      since_step_r   <= since_step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_take || !out_valid_r) begin
      // head entry frees up: refill from skid first to keep order
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= in_acc;
      end else begin
        out_valid_r  <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_word_r  <= skid_word_r;
        skid_word_r <= res;
      end else begin
        out_word_r  <= res;
      end
    end else if (in_acc) begin
      skid_word_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_action          = out_word_r.action;
  assign out_motor_speed     = out_word_r.motor_speed;
  assign out_steer_angle     = out_word_r.steer_angle;
  assign out_brake_front     = out_word_r.brake_front;
  assign out_brake_rear      = out_word_r.brake_rear;
  assign out_failsafe_active = out_word_r.failsafe_active;

  // skid entry is only ever filled behind a waiting head entry
  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid without head entry");

  // emergency stop leaves speed and angle at zero
  a_estop_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_req_type == dcfr_pkg::REQ_PACKET && in_command == dcfr_pkg::CMD_ESTOP)
    |=> (speed_r == 8'sd0 && angle_r == 8'sd0))
    else $error("emergency stop did not clear speed and angle");

  // any known command clears the watchdog
  a_packet_clears_watchdog: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_req_type == dcfr_pkg::REQ_PACKET && in_command[2] == 1'b0)
    |=> (since_packet_r == '0))
    else $error("known command did not clear time since packet");

  // steering stays within servo range
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    (angle_r <= 8'sd90 && angle_r >= -8'sd90))
    else $error("steering angle out of range");

  // a word arriving with a free head entry shows up on the next cycle
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !skid_valid_r && (out_take || !out_valid_r)) |=> out_valid_r)
    else $error("accepted word did not reach the output");

endmodule
